[hw/rtl/first_fit_pool_allocator_defines.svh]
// Assertion macros for the pool allocator.
// Each check is sampled on the rising clock edge and is switched off during reset.
`ifndef FIRST_FIT_POOL_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPA_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPA_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[hw/rtl/fpa_pkg.sv]
package fpa_pkg;

  localparam int FreeSlotsDef  = 32;
  localparam int AllocSlotsDef = 32;
  localparam int MetaWordsDef  = 128;

  localparam logic [15:0] PoolWordsRst = 16'hFFFF;
  localparam logic [15:0] WordMax      = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMBINE = 2'd2,
    OP_RESET   = 2'd3
  } op_e;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNoExtent = 2'd1;
  localparam logic [1:0] StatNoHandle = 2'd2;
  localparam logic [1:0] StatNotFound = 2'd3;

  typedef struct packed {
    op_e         operation;
    logic [15:0] size_words;
    logic [15:0] address;
    logic [31:0] fill_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_address;
    logic [4:0]  handle;
    logic [15:0] block_words;
    logic [31:0] fill_out;
    logic [5:0]  free_slots_used;
  } rsp_t;

endpackage

[hw/rtl/fpa_stream_if.sv]
interface fpa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/first_fit_pool_allocator.sv]
// First-fit word-pool allocator. Each request word carries one operation (alloc, free,
// combine or pool reset) and produces exactly one response word. Requests are taken one
// at a time: the block is ready only when idle. A pool reset clears the tables and then
// hands its response over; an alloc walks the free-extent table and then the handle
// table, one slot per cycle; a free walks the handle table and then the free table in
// the same way; a combine visits each free slot and, for each valid one, scans the
// table with the shared end-of-extent adder and comparator for an extent that ends at
// its start. After reset the block sets up the initial free extent in its init state
// before it accepts a request.
`include "first_fit_pool_allocator_defines.svh"

module first_fit_pool_allocator #(
  parameter int FREE_SLOTS  = fpa_pkg::FreeSlotsDef,
  parameter int ALLOC_SLOTS = fpa_pkg::AllocSlotsDef,
  parameter int META_WORDS  = fpa_pkg::MetaWordsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  fpa_stream_if.sink   req_i,
  fpa_stream_if.source rsp_o
);
  import fpa_pkg::*;

  localparam int FI = $clog2(FREE_SLOTS);
  localparam int AI = $clog2(ALLOC_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam logic [FI-1:0] FLast = FI'(FREE_SLOTS - 1);
  localparam logic [AI-1:0] ALast = AI'(ALLOC_SLOTS - 1);
  localparam logic [15:0]   Meta  = 16'(META_WORDS);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PRST, ST_A_FREE, ST_A_HANDLE, ST_A_WRITE,
    ST_F_ALLOC, ST_F_SLOT, ST_F_WRITE, ST_C_LOAD, ST_C_SCAN, ST_RESP
  } state_e;

  state_e state_q;

  // Descriptor tables.
  logic [15:0] fstart_q [FREE_SLOTS];
  logic [15:0] flen_q   [FREE_SLOTS];
  logic [15:0] astart_q [ALLOC_SLOTS];
  logic [15:0] alen_q   [ALLOC_SLOTS];
  logic [FREE_SLOTS-1:0]  fvalid_q;
  logic [ALLOC_SLOTS-1:0] used_q;
  logic [CW-1:0]          cnt_q;
  logic [15:0]            pool_q;

  // Request latches and walk counters.
  logic [15:0] size_q, addr_q, base_q, len_q, cstart_q, clen_q;
  logic [31:0] fill_q;
  logic [FI-1:0] fi_q, ci_q, fsel_q;
  logic [AI-1:0] ai_q, hsel_q;
  rsp_t res_q, out_q;
  logic out_valid_q;

  // Shared read port of the free table.
  logic [FI-1:0] frd_idx;
  logic [15:0]   fs_rd, fl_rd;
  assign frd_idx = (state_q == ST_C_LOAD) ? ci_q : fi_q;
  assign fs_rd   = fstart_q[frd_idx];
  assign fl_rd   = flen_q[frd_idx];

  // Shared arithmetic: need, fit compare, end-of-extent compare and saturating sum.
  logic [16:0] need, csum;
  logic [15:0] newlen, fend;
  logic        fit, chit;
  assign need   = {1'b0, size_q} + 17'd1;
  assign fit    = fvalid_q[fi_q] && ({1'b0, fl_rd} >= need);
  assign newlen = len_q - need[15:0];
  assign fend   = fs_rd + fl_rd;
  assign chit   = (fi_q != ci_q) && fvalid_q[fi_q] && (fend == cstart_q);
  assign csum   = {1'b0, fl_rd} + {1'b0, clen_q};

  // Free-table write port.
  logic          fw_en;
  logic [FI-1:0] fw_idx;
  logic [15:0]   fw_start, fw_len;
  always_comb begin
    fw_en    = 1'b0;
    fw_idx   = fsel_q;
    fw_start = fs_rd;
    fw_len   = fl_rd;
    unique case (state_q)
      ST_INIT, ST_PRST: begin
        fw_en    = 1'b1;
        fw_idx   = '0;
        fw_start = Meta;
        fw_len   = pool_q - Meta;
      end
      ST_A_WRITE: begin
        fw_en    = 1'b1;
        fw_start = base_q + need[15:0];
        fw_len   = newlen;
      end
      ST_F_WRITE: begin
        fw_en    = 1'b1;
        fw_start = addr_q - 16'd1;
        fw_len   = (len_q == WordMax) ? WordMax : len_q + 16'd1;
      end
      ST_C_SCAN: begin
        fw_en  = chit;
        fw_idx = fi_q;
        fw_len = csum[16] ? WordMax : csum[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) begin
      fstart_q[fw_idx] <= fw_start;
      flen_q[fw_idx]   <= fw_len;
    end
  end

  // Allocation-table write port, used only when an alloc commits.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_A_WRITE) begin
      astart_q[hsel_q] <= base_q + 16'd1;
      alen_q[hsel_q]   <= size_q;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= PoolWordsRst;
    end else if (cfg_we_i) begin
      pool_q <= cfg_wdata_i;
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      fvalid_q    <= FREE_SLOTS'(1);
      cnt_q       <= CW'(1);
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The response state reloads the output itself when the current word leaves.
      if (rsp_o.valid && rsp_o.ready && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_i.valid) begin
            size_q <= req_i.data.size_words;
            addr_q <= req_i.data.address;
            fill_q <= req_i.data.fill_value;
            res_q  <= '0;
            fi_q   <= '0;
            ai_q   <= '0;
            ci_q   <= '0;
            // A free of address zero never matches a live slot and ends as not found.
            unique case (req_i.data.operation)
              OP_ALLOC:   state_q <= ST_A_FREE;
              OP_COMBINE: state_q <= ST_C_LOAD;
              OP_RESET:   state_q <= ST_PRST;
              OP_FREE:    state_q <= ST_F_ALLOC;
              default:    state_q <= ST_RESP;
            endcase
          end
        end
        ST_PRST: begin
          used_q   <= '0;
          fvalid_q <= FREE_SLOTS'(pool_q > Meta);
          cnt_q    <= CW'(pool_q > Meta);
          state_q  <= ST_RESP;
        end
        // First fit over the free extents.
        ST_A_FREE: begin
          if (fit) begin
            fsel_q  <= fi_q;
            base_q  <= fs_rd;
            len_q   <= fl_rd;
            state_q <= ST_A_HANDLE;
          end else if (fi_q == FLast) begin
            res_q.status <= StatNoExtent;
            state_q      <= ST_RESP;
          end else begin
            fi_q <= fi_q + 1'b1;
          end
        end
        ST_A_HANDLE: begin
          if (!used_q[ai_q]) begin
            hsel_q  <= ai_q;
            state_q <= ST_A_WRITE;
          end else if (ai_q == ALast) begin
            res_q.status <= StatNoHandle;
            state_q      <= ST_RESP;
          end else begin
            ai_q <= ai_q + 1'b1;
          end
        end
        ST_A_WRITE: begin
          if (newlen == '0) begin
            fvalid_q[fsel_q] <= 1'b0;
            cnt_q            <= cnt_q - 1'b1;
          end
          // A start that wraps to zero reads as an empty slot.
          used_q[hsel_q]      <= (base_q + 16'd1) != '0;
          res_q.status        <= StatOk;
          res_q.block_address <= base_q + 16'd1;
          res_q.handle        <= 5'(hsel_q);
          res_q.block_words   <= size_q;
          res_q.fill_out      <= fill_q;
          state_q             <= ST_RESP;
        end
        // Look the address up among the live allocations.
        ST_F_ALLOC: begin
          if (used_q[ai_q] && astart_q[ai_q] == addr_q) begin
            hsel_q  <= ai_q;
            len_q   <= alen_q[ai_q];
            state_q <= ST_F_SLOT;
          end else if (ai_q == ALast) begin
            res_q.status <= StatNotFound;
            state_q      <= ST_RESP;
          end else begin
            ai_q <= ai_q + 1'b1;
          end
        end
        ST_F_SLOT: begin
          if (!fvalid_q[fi_q]) begin
            fsel_q  <= fi_q;
            state_q <= ST_F_WRITE;
          end else if (fi_q == FLast) begin
            res_q.status <= StatNoExtent;
            state_q      <= ST_RESP;
          end else begin
            fi_q <= fi_q + 1'b1;
          end
        end
        ST_F_WRITE: begin
          fvalid_q[fsel_q] <= 1'b1;
          cnt_q            <= cnt_q + 1'b1;
          used_q[hsel_q]   <= 1'b0;
          state_q          <= ST_RESP;
        end
        // Combine: outer slot loaded, then the other slots checked until one ends where it starts.
        ST_C_LOAD: begin
          if (fvalid_q[ci_q]) begin
            cstart_q <= fs_rd;
            clen_q   <= fl_rd;
            fi_q     <= '0;
            state_q  <= ST_C_SCAN;
          end else if (ci_q == FLast) begin
            state_q <= ST_RESP;
          end else begin
            ci_q <= ci_q + 1'b1;
          end
        end
        ST_C_SCAN: begin
          if (chit || fi_q == FLast) begin
            if (chit) begin
              fvalid_q[ci_q] <= 1'b0;
              cnt_q          <= cnt_q - 1'b1;
            end
            if (ci_q == FLast) begin
              state_q <= ST_RESP;
            end else begin
              ci_q    <= ci_q + 1'b1;
              state_q <= ST_C_LOAD;
            end
          end else begin
            fi_q <= fi_q + 1'b1;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_q       <= '{status:          res_q.status,
                             block_address:   res_q.block_address,
                             handle:          res_q.handle,
                             block_words:     res_q.block_words,
                             fill_out:        res_q.fill_out,
                             free_slots_used: 6'(cnt_q)};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `FPA_ASSERT(a_cnt_matches, clk_i, rst_ni, cnt_q == CW'($countones(fvalid_q)), "free count drift")
  `FPA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(FREE_SLOTS), "free count overflow")
  `FPA_ASSERT_IMPL(a_busy, clk_i, rst_ni, req_i.valid && req_i.ready, state_q != ST_IDLE, "accepted word not worked on")

endmodule
